// ===== design/tehta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tehta_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC_HIGH = 2'd0,
    OP_CLEAR_HIGH = 2'd1,
    OP_ALLOC_LOW  = 2'd2,
    OP_FREE_LOW   = 2'd3
  } op_e;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoSpace   = 2'd1;
  localparam logic [1:0] StatusBadMagic  = 2'd2;
  localparam logic [1:0] StatusStackFull = 2'd3;

  localparam logic [1:0] ActNone     = 2'd0;
  localparam logic [1:0] ActCommit   = 2'd1;
  localparam logic [1:0] ActDecommit = 2'd2;

  localparam logic [1:0] CfgBase  = 2'd0;
  localparam logic [1:0] CfgTotal = 2'd1;
  localparam logic [1:0] CfgPerm  = 2'd2;

  localparam logic [31:0] AlignAdd         = 32'h0000_000F;
  localparam logic [31:0] AlignMask        = 32'hFFFF_FFF0;
  localparam logic [31:0] HeaderBytes      = 32'h0000_0010;
  localparam logic [31:0] ShortCommitLimit = 32'h0002_0000;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== design/tehta_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tehta_alu (
  input  tehta_pkg::alu_req_t req_i,
  input  logic [30:0]         total_i,
  output logic [31:0]         sum_o,
  output logic                gt_total_o
);
  import tehta_pkg::*;

  logic [31:0] b_eff;
  logic [32:0] full;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign full  = {1'b0, req_i.a} + {1'b0, b_eff} + {32'd0, req_i.sub};
  assign sum_o = full[31:0];

  // Only meaningful for an add: the true 33-bit sum against the region size.
  assign gt_total_o = !req_i.sub && (full > {2'b00, total_i});

endmodule

`default_nettype wire

// ===== design/tehta_rec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tehta_rec #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  input  logic [31:0]      wr_payload_i,
  input  logic [31:0]      wr_length_i,
  input  logic             clr_en_i,
  input  logic [IdxW-1:0]  clr_idx_i,
  input  logic [IdxW-1:0]  rd_idx_i,
  output logic [31:0]      rd_payload_o,
  output logic [31:0]      rd_length_o,
  output logic [Depth-1:0] live_o
);

  logic [31:0]      pay_mem [Depth];
  logic [31:0]      len_mem [Depth];
  logic [31:0]      rd_payload_q;
  logic [31:0]      rd_length_q;
  logic [Depth-1:0] live_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pay_mem[wr_idx_i] <= wr_payload_i;
      len_mem[wr_idx_i] <= wr_length_i;
    end
    rd_payload_q <= pay_mem[rd_idx_i];
    rd_length_q  <= len_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      if (clr_en_i) begin
        live_q[clr_idx_i] <= 1'b0;
      end
      if (wr_en_i) begin
        live_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_payload_o = rd_payload_q;
  assign rd_length_o  = rd_length_q;
  assign live_o       = live_q;

endmodule

`default_nettype wire

// ===== design/two_ended_hunk_temp_allocator_core.sv =====
// Each operation runs as a sequence of states: clear high, alloc high (ending early when out
// of space), alloc low (ending early when out of space or when the stack is full), and free
// low, which scans records from the top and, on a hit, pops dead records off the top.
// One 32-bit adder is shared by every address and length computation; busy_o is high from transfer to result.
// The receiver cannot stall: the strobe lasts one cycle and a new transfer may start then.
// Reset is asynchronous, active low, and clears cursors, count, live bits and config.
`timescale 1ns / 1ps
`default_nettype none

module two_ended_hunk_temp_allocator_core #(
  parameter int unsigned RECORD_DEPTH = 16,
  parameter int unsigned PAGE_BITS    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [30:0] request_size_i,
  input  logic [31:0] block_address_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] payload_address_o,
  output logic [1:0]  page_action_o,
  output logic [31:0] range_start_o,
  output logic [31:0] range_length_o,
  output logic        short_commit_o
);
  import tehta_pkg::*;

  localparam int unsigned CntW = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned IdxW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(RECORD_DEPTH);
  localparam logic [31:0] PageAdd  = 32'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [31:0] PageMask = ~PageAdd;

  typedef enum logic [4:0] {
    S_IDLE, S_TOP, S_OLDEDGE,
    S_HADD, S_HALN, S_HOVF, S_HPAY, S_HFIN,
    S_CNEW, S_CFIN,
    S_LALIGN, S_LSIZE, S_LHDR, S_LOVF, S_LPAY, S_LPAY16, S_LLEN,
    S_LB0A, S_LB0B, S_LB1A, S_LB1B, S_LFIN,
    S_FREAD, S_FCMP, S_FE0A, S_FE0B, S_FSUB, S_FE1A, S_FE1B, S_FPOP, S_FFIN
  } state_e;

  state_e      state_q;
  op_e         op_q;
  logic [30:0] size_q;
  logic [31:0] addr_q;
  logic [31:0] base_q;
  logic [30:0] total_q;
  logic [30:0] perm_q;
  logic [31:0] top_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic [31:0] old_q;
  logic [31:0] new_q;
  logic [31:0] acc_q;
  logic [31:0] pay_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] scan_q;

  logic        valid_q;
  logic [1:0]  status_q;
  logic [31:0] payload_q;
  logic [1:0]  action_q;
  logic [31:0] rstart_q;
  logic [31:0] rlen_q;
  logic        short_q;

  alu_req_t    alu_req;
  logic [31:0] alu_sum;
  logic        alu_gt;

  logic [CntW-1:0]   scan_m1;
  logic [CntW-1:0]   cnt_m1;
  logic [31:0]       rd_payload;
  logic [31:0]       rd_length;
  logic [RECORD_DEPTH-1:0] live_vec;
  logic              rec_wr;
  logic              rec_clr;
  logic              hit;

  assign scan_m1 = scan_q - CntW'(1);
  assign cnt_m1  = cnt_q - CntW'(1);
  assign hit     = live_vec[scan_q[IdxW-1:0]] && (rd_payload == addr_q);
  assign rec_wr  = (state_q == S_LLEN);
  assign rec_clr = (state_q == S_FCMP) && hit;

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_TOP:     begin alu_req.a = base_q; alu_req.b = {1'b0, total_q}; end
      S_OLDEDGE: begin alu_req.a = top_q; alu_req.b = hi_q; alu_req.sub = 1'b1; end
      S_HADD:    begin alu_req.a = hi_q; alu_req.b = {1'b0, size_q}; end
      S_HALN:    begin alu_req.a = acc_q; alu_req.b = AlignAdd; end
      S_HOVF:    begin alu_req.a = hi_q; alu_req.b = lo_q; end
      S_HPAY:    begin alu_req.a = top_q; alu_req.b = hi_q; alu_req.sub = 1'b1; end
      S_HFIN:    begin alu_req.a = old_q; alu_req.b = acc_q; alu_req.sub = 1'b1; end
      S_CNEW:    begin alu_req.a = top_q; alu_req.b = {1'b0, perm_q}; alu_req.sub = 1'b1; end
      S_CFIN:    begin alu_req.a = acc_q; alu_req.b = old_q; alu_req.sub = 1'b1; end
      S_LALIGN:  begin alu_req.a = lo_q; alu_req.b = AlignAdd; end
      S_LSIZE:   begin alu_req.a = acc_q; alu_req.b = {1'b0, size_q}; end
      S_LHDR:    begin alu_req.a = new_q; alu_req.b = HeaderBytes; end
      S_LOVF:    begin alu_req.a = hi_q; alu_req.b = lo_q; end
      S_LPAY:    begin alu_req.a = base_q; alu_req.b = acc_q; end
      S_LPAY16:  begin alu_req.a = pay_q; alu_req.b = HeaderBytes; end
      S_LLEN:    begin alu_req.a = new_q; alu_req.b = old_q; alu_req.sub = 1'b1; end
      S_LB0A:    begin alu_req.a = base_q; alu_req.b = old_q; end
      S_LB0B:    begin alu_req.a = acc_q; alu_req.b = PageAdd; end
      S_LB1A:    begin alu_req.a = base_q; alu_req.b = new_q; end
      S_LB1B:    begin alu_req.a = acc_q; alu_req.b = PageAdd; end
      S_LFIN:    begin alu_req.a = new_q; alu_req.b = old_q; alu_req.sub = 1'b1; end
      S_FE0A:    begin alu_req.a = base_q; alu_req.b = lo_q; end
      S_FE0B:    begin alu_req.a = acc_q; alu_req.b = PageAdd; end
      S_FSUB:    begin alu_req.a = lo_q; alu_req.b = pay_q; alu_req.sub = 1'b1; end
      S_FE1A:    begin alu_req.a = base_q; alu_req.b = lo_q; end
      S_FE1B:    begin alu_req.a = acc_q; alu_req.b = PageAdd; end
      S_FFIN:    begin alu_req.a = old_q; alu_req.b = new_q; alu_req.sub = 1'b1; end
      default:   ;
    endcase
  end

  tehta_alu u_alu (
    .req_i      (alu_req),
    .total_i    (total_q),
    .sum_o      (alu_sum),
    .gt_total_o (alu_gt)
  );

  tehta_rec #(
    .Depth (RECORD_DEPTH),
    .IdxW  (IdxW)
  ) u_rec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (rec_wr),
    .wr_idx_i     (cnt_q[IdxW-1:0]),
    .wr_payload_i (pay_q),
    .wr_length_i  (alu_sum),
    .clr_en_i     (rec_clr),
    .clr_idx_i    (scan_q[IdxW-1:0]),
    .rd_idx_i     (scan_m1[IdxW-1:0]),
    .rd_payload_o (rd_payload),
    .rd_length_o  (rd_length),
    .live_o       (live_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ALLOC_HIGH;
      size_q    <= '0;
      addr_q    <= '0;
      base_q    <= '0;
      total_q   <= '0;
      perm_q    <= '0;
      top_q     <= '0;
      hi_q      <= '0;
      lo_q      <= '0;
      old_q     <= '0;
      new_q     <= '0;
      acc_q     <= '0;
      pay_q     <= '0;
      cnt_q     <= '0;
      scan_q    <= '0;
      valid_q   <= 1'b0;
      status_q  <= StatusOk;
      payload_q <= '0;
      action_q  <= ActNone;
      rstart_q  <= '0;
      rlen_q    <= '0;
      short_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgBase:  base_q  <= cfg_data_i;
          CfgTotal: total_q <= cfg_data_i[30:0];
          CfgPerm:  perm_q  <= cfg_data_i[30:0];
          default:  ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= op_e'(opcode_i);
            size_q  <= request_size_i;
            addr_q  <= block_address_i;
            state_q <= S_TOP;
          end
        end
        S_TOP: begin
          top_q  <= alu_sum;
          scan_q <= cnt_q;
          case (op_q)
            OP_ALLOC_HIGH, OP_CLEAR_HIGH: state_q <= S_OLDEDGE;
            OP_ALLOC_LOW: begin
              if (cnt_q >= DepthCnt) begin
                valid_q   <= 1'b1;
                status_q  <= StatusStackFull;
                payload_q <= '0;
                action_q  <= ActNone;
                rstart_q  <= '0;
                rlen_q    <= '0;
                short_q   <= 1'b0;
                state_q   <= S_IDLE;
              end else begin
                state_q <= S_LALIGN;
              end
            end
            default: state_q <= S_FREAD;
          endcase
        end
        S_OLDEDGE: begin
          old_q   <= alu_sum & PageMask;
          state_q <= (op_q == OP_CLEAR_HIGH) ? S_CNEW : S_HADD;
        end
        S_HADD: begin
          acc_q   <= alu_sum;
          state_q <= S_HALN;
        end
        S_HALN: begin
          hi_q    <= alu_sum & AlignMask;
          state_q <= S_HOVF;
        end
        S_HOVF, S_LOVF: begin
          if (alu_gt) begin
            valid_q   <= 1'b1;
            status_q  <= StatusNoSpace;
            payload_q <= '0;
            action_q  <= ActNone;
            rstart_q  <= '0;
            rlen_q    <= '0;
            short_q   <= 1'b0;
            state_q   <= S_IDLE;
          end else begin
            state_q <= (state_q == S_HOVF) ? S_HPAY : S_LPAY;
          end
        end
        S_HPAY: begin
          pay_q   <= alu_sum;
          acc_q   <= alu_sum & PageMask;
          state_q <= S_HFIN;
        end
        S_HFIN: begin
          valid_q   <= 1'b1;
          status_q  <= StatusOk;
          payload_q <= pay_q;
          action_q  <= (acc_q != old_q) ? ActCommit : ActNone;
          rstart_q  <= (acc_q != old_q) ? acc_q : 32'd0;
          rlen_q    <= (acc_q != old_q) ? alu_sum : 32'd0;
          short_q   <= (acc_q != old_q) && (alu_sum <= ShortCommitLimit);
          state_q   <= S_IDLE;
        end
        S_CNEW: begin
          acc_q   <= alu_sum & PageMask;
          hi_q    <= {1'b0, perm_q};
          state_q <= S_CFIN;
        end
        S_CFIN: begin
          valid_q   <= 1'b1;
          status_q  <= StatusOk;
          payload_q <= '0;
          action_q  <= (acc_q != old_q) ? ActDecommit : ActNone;
          rstart_q  <= (acc_q != old_q) ? old_q : 32'd0;
          rlen_q    <= (acc_q != old_q) ? alu_sum : 32'd0;
          short_q   <= 1'b0;
          state_q   <= S_IDLE;
        end
        S_LALIGN: begin
          acc_q   <= alu_sum & AlignMask;
          old_q   <= lo_q;
          state_q <= S_LSIZE;
        end
        S_LSIZE: begin
          new_q   <= alu_sum;
          state_q <= S_LHDR;
        end
        S_LHDR: begin
          new_q   <= alu_sum;
          lo_q    <= alu_sum;
          state_q <= S_LOVF;
        end
        S_LPAY: begin
          pay_q   <= alu_sum;
          state_q <= S_LPAY16;
        end
        S_LPAY16: begin
          pay_q   <= alu_sum;
          state_q <= S_LLEN;
        end
        S_LLEN: begin
          cnt_q   <= cnt_q + CntW'(1);
          state_q <= S_LB0A;
        end
        S_LB0A: begin
          acc_q   <= alu_sum;
          state_q <= S_LB0B;
        end
        S_LB0B: begin
          old_q   <= alu_sum & PageMask;
          state_q <= S_LB1A;
        end
        S_LB1A: begin
          acc_q   <= alu_sum;
          state_q <= S_LB1B;
        end
        S_LB1B: begin
          new_q   <= alu_sum & PageMask;
          state_q <= S_LFIN;
        end
        S_LFIN: begin
          valid_q   <= 1'b1;
          status_q  <= StatusOk;
          payload_q <= pay_q;
          action_q  <= (new_q != old_q) ? ActCommit : ActNone;
          rstart_q  <= (new_q != old_q) ? old_q : 32'd0;
          rlen_q    <= (new_q != old_q) ? alu_sum : 32'd0;
          short_q   <= (new_q != old_q) && (alu_sum <= ShortCommitLimit);
          state_q   <= S_IDLE;
        end
        S_FREAD: begin
          if (scan_q == '0) begin
            valid_q   <= 1'b1;
            status_q  <= StatusBadMagic;
            payload_q <= '0;
            action_q  <= ActNone;
            rstart_q  <= '0;
            rlen_q    <= '0;
            short_q   <= 1'b0;
            state_q   <= S_IDLE;
          end else begin
            scan_q  <= scan_m1;
            state_q <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (hit) begin
            pay_q   <= rd_length;
            state_q <= S_FE0A;
          end else begin
            state_q <= S_FREAD;
          end
        end
        S_FE0A: begin
          acc_q   <= alu_sum;
          state_q <= S_FE0B;
        end
        S_FE0B: begin
          old_q   <= alu_sum & PageMask;
          state_q <= S_FSUB;
        end
        S_FSUB: begin
          lo_q    <= alu_sum;
          state_q <= S_FE1A;
        end
        S_FE1A: begin
          acc_q   <= alu_sum;
          state_q <= S_FE1B;
        end
        S_FE1B: begin
          new_q   <= alu_sum & PageMask;
          state_q <= S_FPOP;
        end
        S_FPOP: begin
          if ((cnt_q != '0) && !live_vec[cnt_m1[IdxW-1:0]]) begin
            cnt_q <= cnt_m1;
          end else begin
            state_q <= S_FFIN;
          end
        end
        S_FFIN: begin
          valid_q   <= 1'b1;
          status_q  <= StatusOk;
          payload_q <= '0;
          action_q  <= (old_q != new_q) ? ActDecommit : ActNone;
          rstart_q  <= (old_q != new_q) ? new_q : 32'd0;
          rlen_q    <= (old_q != new_q) ? alu_sum : 32'd0;
          short_q   <= 1'b0;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign result_valid_o    = valid_q;
  assign status_o          = status_q;
  assign payload_address_o = payload_q;
  assign page_action_o     = action_q;
  assign range_start_o     = rstart_q;
  assign range_length_o    = rlen_q;
  assign short_commit_o    = short_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("record count exceeds the stack depth");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer accepted but block not busy");

  a_no_range_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != StatusOk)) |->
      ((page_action_o == ActNone) && (range_length_o == 32'd0) && !short_commit_o))
    else $error("failed operation reported a page range");
`endif

endmodule

`default_nettype wire

// ===== verif/hunk_alloc_checker.sv =====
`timescale 1ns / 1ps

module hunk_alloc_checker #(
  parameter int unsigned RecordDepth = 16,
  parameter int unsigned PageBits    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [30:0] request_size_i,
  input  logic [31:0] block_address_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        result_valid_o,
  input  logic [1:0]  status_o,
  input  logic [31:0] payload_address_o,
  input  logic [1:0]  page_action_o,
  input  logic [31:0] range_start_o,
  input  logic [31:0] range_length_o,
  input  logic        short_commit_o,
  output int          mismatches_o,
  output int          pending_o
);
  import tehta_pkg::*;

  localparam logic [31:0] PageMask = (32'd1 << PageBits) - 32'd1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload;
    logic [1:0]  action;
    logic [31:0] start;
    logic [31:0] length;
    logic        short_commit;
  } hunk_result_t;

  logic [31:0] region_base;
  logic [31:0] region_bytes;
  logic [31:0] high_floor;
  logic [31:0] high_used;
  logic [31:0] low_used;
  logic [31:0] rec_payload [RecordDepth];
  logic [31:0] rec_length [RecordDepth];
  bit          rec_live [RecordDepth];
  int          rec_count;

  hunk_result_t expected_results[$];
  hunk_result_t want;

  function automatic logic [31:0] page_down(input logic [31:0] a);
    return a & ~PageMask;
  endfunction

  function automatic logic [31:0] page_up(input logic [31:0] a);
    return page_down(a + PageMask);
  endfunction

  function automatic bit fits(input logic [31:0] hi, input logic [31:0] lo);
    return ({1'b0, hi} + {1'b0, lo}) <= {1'b0, region_bytes};
  endfunction

  function automatic hunk_result_t pack_result(input logic [1:0] st, input logic [31:0] pay,
                                               input logic [1:0] act, input logic [31:0] rs,
                                               input logic [31:0] rl);
    hunk_result_t r;
    r.status       = st;
    r.payload      = pay;
    r.action       = act;
    r.start        = (act == ActNone) ? 32'd0 : rs;
    r.length       = (act == ActNone) ? 32'd0 : rl;
    r.short_commit = (act == ActCommit) && (rl <= ShortCommitLimit);
    return r;
  endfunction

  function automatic hunk_result_t predict_hunk_op(input op_e op, input logic [31:0] size,
                                                   input logic [31:0] addr);
    logic [31:0] top;
    logic [31:0] old_edge;
    logic [31:0] new_edge;
    logic [31:0] prev;
    logic [31:0] aligned;
    logic [31:0] pay;
    int hit;
    hunk_result_t res;
    top = region_base + region_bytes;
    res = pack_result(StatusOk, 32'd0, ActNone, 32'd0, 32'd0);
    hit = -1;
    case (op)
      OP_ALLOC_HIGH: begin
        old_edge = page_down(top - high_used);
        high_used = (high_used + size + AlignAdd) & AlignMask;
        if (!fits(high_used, low_used)) begin
          res = pack_result(StatusNoSpace, 32'd0, ActNone, 32'd0, 32'd0);
        end else begin
          pay = top - high_used;
          new_edge = page_down(pay);
          res = pack_result(StatusOk, pay, (new_edge != old_edge) ? ActCommit : ActNone,
                            new_edge, old_edge - new_edge);
        end
      end
      OP_CLEAR_HIGH: begin
        old_edge = page_down(top - high_used);
        new_edge = page_down(top - high_floor);
        high_used = high_floor;
        res = pack_result(StatusOk, 32'd0, (new_edge != old_edge) ? ActDecommit : ActNone,
                          old_edge, new_edge - old_edge);
      end
      OP_ALLOC_LOW: begin
        if (rec_count >= RecordDepth) begin
          res = pack_result(StatusStackFull, 32'd0, ActNone, 32'd0, 32'd0);
        end else begin
          prev = low_used;
          aligned = (prev + AlignAdd) & AlignMask;
          low_used = aligned + size + HeaderBytes;
          if (!fits(high_used, low_used)) begin
            res = pack_result(StatusNoSpace, 32'd0, ActNone, 32'd0, 32'd0);
          end else begin
            pay = region_base + aligned + HeaderBytes;
            rec_payload[rec_count] = pay;
            rec_length[rec_count] = low_used - prev;
            rec_live[rec_count] = 1'b1;
            rec_count++;
            old_edge = page_up(region_base + prev);
            new_edge = page_up(region_base + low_used);
            res = pack_result(StatusOk, pay, (new_edge != old_edge) ? ActCommit : ActNone,
                              old_edge, new_edge - old_edge);
          end
        end
      end
      default: begin
        for (int i = rec_count - 1; i >= 0; i--) begin
          if (hit < 0 && rec_live[i] && rec_payload[i] == addr) hit = i;
        end
        if (hit < 0) begin
          res = pack_result(StatusBadMagic, 32'd0, ActNone, 32'd0, 32'd0);
        end else begin
          rec_live[hit] = 1'b0;
          old_edge = page_up(region_base + low_used);
          low_used = low_used - rec_length[hit];
          new_edge = page_up(region_base + low_used);
          while (rec_count > 0 && !rec_live[rec_count - 1]) rec_count--;
          res = pack_result(StatusOk, 32'd0, (new_edge != old_edge) ? ActDecommit : ActNone,
                            new_edge, old_edge - new_edge);
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      region_base = '0;
      region_bytes = '0;
      high_floor = '0;
      high_used = '0;
      low_used = '0;
      rec_count = 0;
      for (int i = 0; i < RecordDepth; i++) rec_live[i] = 1'b0;
      expected_results.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgBase:  region_base = cfg_data_i;
          CfgTotal: region_bytes = {1'b0, cfg_data_i[30:0]};
          CfgPerm:  high_floor = {1'b0, cfg_data_i[30:0]};
          default: ;
        endcase
      end
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("payload_address", want.payload, payload_address_o);
          check_field("page_action", 32'(want.action), 32'(page_action_o));
          check_field("range_start", want.start, range_start_o);
          check_field("range_length", want.length, range_length_o);
          check_field("short_commit", 32'(want.short_commit), 32'(short_commit_o));
        end
      end
      if (start_i && !busy_o) begin
        expected_results.push_back(predict_hunk_op(op_e'(opcode_i), {1'b0, request_size_i},
                                                   block_address_i));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== verif/two_ended_hunk_temp_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module two_ended_hunk_temp_allocator_core_tb;
  import tehta_pkg::*;

  localparam int unsigned RecordDepth = 16;
  localparam int unsigned PageBits    = 12;
  localparam int          CycleLimit  = 1_000_000;
  localparam int          NumPhases   = 8;
  localparam int          PhaseItems  = 230;
  localparam int          TightPhase  = 5;
  localparam int          SettleCycles = 70;
  localparam logic [31:0] DirBase     = 32'h4000_0800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = OP_ALLOC_HIGH;
  logic [30:0] request_size_i = '0;
  logic [31:0] block_address_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgBase;
  logic [31:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] payload_address_o;
  logic [1:0]  page_action_o;
  logic [31:0] range_start_o;
  logic [31:0] range_length_o;
  logic        short_commit_o;

  int          mismatches;
  int          pending_results;
  int          cycles = 0;
  op_e         issued_ops[$];
  logic [31:0] live_blocks[$];
  bit          track_blocks = 1'b0;

  two_ended_hunk_temp_allocator_core #(
    .RECORD_DEPTH(RecordDepth),
    .PAGE_BITS   (PageBits)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .payload_address_o(payload_address_o),
    .page_action_o    (page_action_o),
    .range_start_o    (range_start_o),
    .range_length_o   (range_length_o),
    .short_commit_o   (short_commit_o)
  );

  hunk_alloc_checker #(
    .RecordDepth(RecordDepth),
    .PageBits   (PageBits)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .payload_address_o(payload_address_o),
    .page_action_o    (page_action_o),
    .range_start_o    (range_start_o),
    .range_length_o   (range_length_o),
    .short_commit_o   (short_commit_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("two_ended_hunk_temp_allocator_core: mismatch");
      $finish;
    end
  end

  // Payload addresses of successful low allocations feed the free requests.
  always @(posedge clk_i) begin
    if (result_valid_o && issued_ops.size() != 0) begin
      if (issued_ops.pop_front() == OP_ALLOC_LOW && status_o == StatusOk && track_blocks)
        live_blocks.push_back(payload_address_o);
    end
  end

  task automatic issue(input op_e op, input logic [30:0] size, input logic [31:0] addr);
    start_i <= 1'b1;
    opcode_i <= op;
    request_size_i <= size;
    block_address_i <= addr;
    issued_ops.push_back(op);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_region(input logic [31:0] base, input logic [31:0] bytes,
                            input logic [31:0] floor);
    drain();
    write_reg(CfgBase, base);
    write_reg(CfgTotal, bytes);
    write_reg(CfgPerm, floor);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    op_e         op;
    logic [30:0] size;
    logic [31:0] addr;
    logic [31:0] base;
    logic [31:0] bytes;
    logic [31:0] floor;
    logic [31:0] last_freed;
    int          size_cap;
    int          pick;
    int          high_allocs;
    int          fill_left;
    last_freed = '0;
    fill_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first two low allocations wrap the low cursor around 32 bits; the record that the
    // third low allocation leaves sits at the bottom of the stack for the rest of the run.
    set_region(DirBase, 32'h7FFF_FFFF, 32'h100);
    issue(OP_ALLOC_LOW, 31'h7FFF_FFFF, 32'h0);
    issue(OP_ALLOC_LOW, 31'h7FFF_FFE0, 32'h0);
    issue(OP_FREE_LOW, 31'h0, DirBase + 32'h8000_0020);
    issue(OP_ALLOC_LOW, 31'h7FFF_FFE0, 32'h0);
    issue(OP_ALLOC_HIGH, 31'h0, 32'h0);
    issue(OP_ALLOC_HIGH, 31'h2_0000, 32'h0);
    issue(OP_ALLOC_HIGH, 31'h3_0000, 32'h0);
    issue(OP_ALLOC_HIGH, 31'h7FFF_FFFF, 32'h0);
    issue(OP_CLEAR_HIGH, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_CLEAR_HIGH, 31'h0, 32'h0);
    issue(OP_ALLOC_LOW, 31'h0, 32'h0);
    issue(OP_ALLOC_LOW, 31'h1234, 32'h0);
    issue(OP_FREE_LOW, 31'h0, 32'hFFFF_FFFF);
    issue(OP_FREE_LOW, 31'h0, DirBase + 32'h10);
    issue(OP_FREE_LOW, 31'h0, DirBase + 32'h20);
    issue(OP_FREE_LOW, 31'h0, DirBase + 32'h20);
    issue(OP_ALLOC_HIGH, 31'h123, 32'h0);
    set_region(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    issue(OP_CLEAR_HIGH, 31'h0, 32'h0);
    issue(OP_ALLOC_HIGH, 31'h5, 32'h0);
    issue(OP_FREE_LOW, 31'h0, 32'h0);

    track_blocks = 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) base = 32'h0;
      else if (p == 1) base = 32'hFFFF_FFFF;
      else base = $urandom();
      if (p == TightPhase) bytes = $urandom_range(32'h4_0000, 32'h2000);
      else if (p == 2) bytes = 32'h7FFF_FFFF;
      else bytes = $urandom_range(32'h7FFF_FFFF, 32'h80_0000);
      if (p == 3) floor = 32'h0;
      else if (p == TightPhase) floor = $urandom_range(bytes / 4, 0);
      else floor = $urandom_range(32'h4_0000, 0);
      size_cap = (p == TightPhase) ? 32'h1000 : 32'h3_0000;
      set_region(base, bytes, floor);
      high_allocs = 0;
      issue(OP_CLEAR_HIGH, 31'h0, 32'h0);

      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) size = 31'($urandom_range(size_cap, 0));
        else if (pick < 3) size = 31'($urandom_range(31, 0));
        else size = 31'($urandom_range((size_cap < 32'h3000) ? size_cap : 32'h3000, 0));
        addr = $urandom();
        if (fill_left > 0) begin
          op = OP_ALLOC_LOW;
          fill_left--;
        end else begin
          pick = $urandom_range(99, 0);
          if (pick < 2) begin
            fill_left = RecordDepth;
            op = OP_ALLOC_LOW;
          end else if (pick < 27) begin
            op = (high_allocs >= 12) ? OP_CLEAR_HIGH : OP_ALLOC_HIGH;
          end else if (pick < 35) begin
            op = OP_CLEAR_HIGH;
          end else if (pick < 62) begin
            op = OP_ALLOC_LOW;
          end else if (pick < 90 && live_blocks.size() != 0) begin
            pick = $urandom_range(live_blocks.size() - 1, 0);
            addr = live_blocks[pick];
            live_blocks.delete(pick);
            last_freed = addr;
            op = OP_FREE_LOW;
          end else begin
            op = OP_FREE_LOW;
            pick = $urandom_range(2, 0);
            if (pick == 0) addr = last_freed;
            else if (pick == 1 && live_blocks.size() != 0) addr = live_blocks[0] + 32'h10;
          end
        end
        if (op == OP_ALLOC_HIGH) high_allocs++;
        else if (op == OP_CLEAR_HIGH) high_allocs = 0;
        issue(op, size, addr);
        if (p < NumPhases - 2 && (n / 40) % 3 != 2 && $urandom_range(4, 0) == 0)
          hold_off($urandom_range(18, 1));
        if (p < NumPhases - 2 && $urandom_range(149, 0) == 0) drain();
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0) begin
      $display("two_ended_hunk_temp_allocator_core: match");
    end else begin
      $display("two_ended_hunk_temp_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
